// ===== hdl/far_pkg.sv =====
// Package for the fraction arithmetic and reduction block.
// Holds the operation codes and sequencer states; depends on nothing.
package far_pkg;
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } state_t;
endpackage

// ===== hdl/fraction_arith_reduce_top.sv =====
// Top level of the fraction arithmetic and reduction block.
// Depends on far_pkg for operation codes and sequencer states.
//
// Usage:
//  - Input channel s_valid/s_ready carries one operation and two signed
//    fractions num_a/den_a and num_b/den_b per beat.
//  - Result channel m_valid/m_ready carries the reduced fraction res_num/res_den
//    and status (1 when the raw denominator is zero, with 0/0).
//  - Each beat gives exactly one result beat.
//  - Sequence: the multiply states MUL1 and MUL2, the combine state COMB, then a
//    shared restoring divider of W2 = 2*OPERAND_WIDTH+1 bits. Euclid's loop
//    uses it for one remainder per step, and then the two final divisions
//    (numerator and denominator by the divisor found) use it as well; a zero
//    numerator or denominator skips the divider.
//  - The shared bit-serial divider sets the rate: one item at a time,
//    s_ready is high only while idle.
//  - A stalled receiver holds the result register; no new beat is taken
//    until the result beat completes.
//  - Reset (aresetn low, synchronous) returns the sequencer to idle and
//    drops any result in flight.
module fraction_arith_reduce_top
    import far_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_req_type,
    input  logic signed [OPERAND_WIDTH-1:0] s_num_a,
    input  logic signed [OPERAND_WIDTH-1:0] s_den_a,
    input  logic signed [OPERAND_WIDTH-1:0] s_num_b,
    input  logic signed [OPERAND_WIDTH-1:0] s_den_b,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [32:0]              m_res_num,
    output logic [30:0]                     m_res_den,
    output logic                            m_status
);
    localparam int W  = OPERAND_WIDTH;
    localparam int WP = 2 * W;      // product magnitude width
    localparam int W2 = WP + 1;     // sum magnitude width
    localparam int CW = $clog2(W2 + 1);

    state_t state_reg, state_next;

    // operand magnitudes and signs
    logic [W-1:0]  ma_reg, mb_reg, mc_reg, md_reg;
    logic          sa_reg, sb_reg, sc_reg, sd_reg;
    op_t           op_reg;
    logic [WP-1:0] p1_reg, p2_reg, pm_reg;
    logic          s1_reg, s2_reg, sm_reg;
    logic [W2-1:0] n_reg, m_reg;
    logic          neg_reg;
    logic [W2-1:0] qn_reg;

    // shared divider: dividend shift register, remainder, divisor
    logic [W2-1:0] dq_reg, rem_reg, dv_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;

    logic [32:0]   onum_reg;
    logic [30:0]   oden_reg;
    logic          ost_reg;

    logic [W-1:0] abs_a, abs_b, abs_c, abs_d;
    assign abs_a = s_num_a[W-1] ? W'(-s_num_a) : W'(s_num_a);
    assign abs_b = s_num_b[W-1] ? W'(-s_num_b) : W'(s_num_b);
    assign abs_c = s_den_a[W-1] ? W'(-s_den_a) : W'(s_den_a);
    assign abs_d = s_den_b[W-1] ? W'(-s_den_b) : W'(s_den_b);

    // divider step: shift one dividend bit into the remainder
    logic [W2:0]   trial;
    logic [W2-1:0] shifted;
    logic          fits;
    assign shifted = {rem_reg[W2-2:0], dq_reg[W2-1]};
    assign trial   = {1'b0, shifted} - {1'b0, dv_reg};
    assign fits    = ~trial[W2] | rem_reg[W2-1];
    logic          div_done;
    assign div_done = busy_reg && (cnt_reg == CW'(W2 - 1));

    // combine signed products into the raw numerator
    logic [W2-1:0] ext1, ext2, cmag;
    logic          csign, s2eff;
    always_comb begin
        ext1  = {1'b0, p1_reg};
        ext2  = {1'b0, p2_reg};
        s2eff = (op_reg == OP_SUB) ? ~s2_reg : s2_reg;
        if (op_reg == OP_MUL || op_reg == OP_DIV) begin
            cmag  = ext1;
            csign = s1_reg;
        end else if (s1_reg == s2eff) begin
            cmag  = ext1 + ext2;
            csign = s1_reg;
        end else if (ext1 >= ext2) begin
            cmag  = ext1 - ext2;
            csign = s1_reg;
        end else begin
            cmag  = ext2 - ext1;
            csign = s2eff;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_COMB;
            ST_COMB: begin
                if (pm_reg == '0 || cmag == '0) state_next = ST_OUT;
                else                             state_next = ST_GCD;
            end
            ST_GCD:  if (div_done && {trial[W2-1:0]} == '0 && fits)
                         state_next = ST_DIVN;
                     else if (div_done && !fits && shifted == '0)
                         state_next = ST_DIVN;
            ST_DIVN: if (div_done) state_next = ST_DIVD;
            ST_DIVD: if (div_done) state_next = ST_OUT;
            ST_OUT:  if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    logic [W2-1:0] rem_fin;
    assign rem_fin = fits ? trial[W2-1:0] : shifted;
    logic [W2-1:0] q_fin;
    assign q_fin = {dq_reg[W2-2:0], fits};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: if (s_valid) begin
                    op_reg <= op_t'(s_req_type);
                    ma_reg <= abs_a; sa_reg <= s_num_a[W-1];
                    mb_reg <= abs_b; sb_reg <= s_num_b[W-1];
                    mc_reg <= abs_c; sc_reg <= s_den_a[W-1];
                    md_reg <= abs_d; sd_reg <= s_den_b[W-1];
                end
                ST_MUL1: begin
                    // a*d (or a*b for multiply) first
                    if (op_reg == OP_MUL) begin
                        p1_reg <= WP'(ma_reg * mb_reg); s1_reg <= sa_reg ^ sb_reg;
                    end else begin
                        p1_reg <= WP'(ma_reg * md_reg); s1_reg <= sa_reg ^ sd_reg;
                    end
                    p2_reg <= WP'(mb_reg * mc_reg); s2_reg <= sb_reg ^ sc_reg;
                end
                ST_MUL2: begin
                    if (op_reg == OP_DIV) begin
                        pm_reg <= WP'(mc_reg * mb_reg); sm_reg <= sc_reg ^ sb_reg;
                    end else begin
                        pm_reg <= WP'(mc_reg * md_reg); sm_reg <= sc_reg ^ sd_reg;
                    end
                end
                ST_COMB: begin
                    n_reg   <= cmag;
                    m_reg   <= {1'b0, pm_reg};
                    neg_reg <= csign ^ sm_reg;
                    // start first Euclid remainder: n mod m
                    dq_reg   <= cmag;
                    dv_reg   <= {1'b0, pm_reg};
                    rem_reg  <= '0;
                    cnt_reg  <= '0;
                    busy_reg <= (pm_reg != '0) && (cmag != '0);
                end
                ST_GCD: begin
                    if (div_done) begin
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        if (rem_fin == '0) begin
                            // divisor found and held in dv: start n / g
                            dq_reg <= n_reg;
                        end else begin
                            // advance Euclid: next remainder dv mod rem
                            dq_reg <= dv_reg;
                            dv_reg <= rem_fin;
                        end
                    end else begin
                        rem_reg <= rem_fin;
                        dq_reg  <= q_fin;
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                ST_DIVN: begin
                    if (div_done) begin
                        qn_reg  <= q_fin;
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        dq_reg  <= m_reg;
                    end else begin
                        rem_reg <= rem_fin;
                        dq_reg  <= q_fin;
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                ST_DIVD: begin
                    if (div_done) begin
                        busy_reg <= 1'b0;
                        cnt_reg  <= '0;
                        onum_reg <= neg_reg ? 33'(-{1'b0, qn_reg}) : 33'(qn_reg);
                        oden_reg <= 31'(q_fin);
                        ost_reg  <= 1'b0;
                    end else begin
                        rem_reg <= rem_fin;
                        dq_reg  <= q_fin;
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                default: ;
            endcase
            if (state_reg == ST_COMB) begin
                if (pm_reg == '0) begin
                    onum_reg <= '0; oden_reg <= '0; ost_reg <= 1'b1;
                end else if (cmag == '0) begin
                    onum_reg <= '0; oden_reg <= 31'd1; ost_reg <= 1'b0;
                end
            end
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign m_res_num = onum_reg;
    assign m_res_den = oden_reg;
    assign m_status  = ost_reg;

    // invalid results always carry 0/0
    a_inv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_res_num == '0 && m_res_den == '0))
        else $error("invalid result not 0/0");
    // valid results have a nonzero denominator
    a_den_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_status) |-> (m_res_den != '0))
        else $error("valid result with zero denominator");
    // the divider is idle whenever the block can take a beat
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !busy_reg)
        else $error("divider busy while idle");
endmodule
